[sv/cidwl_pkg.sv]
// Types and codes shared by the card ID whitelist table.
// No dependencies; every other file imports this package.
package cidwl_pkg;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_DUPLICATE = 2'd1;
   localparam logic [1:0] ST_ABSENT    = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] card_id;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [6:0] slot;
      logic [6:0] entry_count;
      logic       is_master;
      logic [1:0] status;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic search;
      logic shift_init;
      logic shift;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic search_done;
      logic hit;
      logic is_delete;
      logic shift_done;
   } sts_type;

endpackage

[sv/cidwl_ctrl.sv]
// Controller of the card ID whitelist table: search, shift and finish sequencing.
// Depends on cidwl_pkg.
module cidwl_ctrl import cidwl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   output logic      busy,
   input  sts_type   sts,
   output cmd_type   cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_SEARCH;
         end
         S_SEARCH: begin
            if (sts.search_done) begin
               if (sts.is_delete && sts.hit) state_in = S_SHIFT;
               else state_in = S_FINISH;
            end
         end
         S_SHIFT: begin
            if (sts.shift_done) state_in = S_FINISH;
         end
         S_FINISH: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE: cmd.load = start;
         S_SEARCH: begin
            cmd.search     = 1'b1;
            cmd.shift_init = sts.search_done && sts.is_delete && sts.hit;
         end
         S_SHIFT:  cmd.shift  = 1'b1;
         S_FINISH: cmd.finish = 1'b1;
         default:  cmd = '0;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

[sv/cidwl_dp.sv]
// Datapath of the card ID whitelist table: ID memory, pointers, compare and result.
// Depends on cidwl_pkg; driven by cidwl_ctrl.
module cidwl_dp import cidwl_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  req_type     req_data,
   input  logic        csr_valid,
   input  logic [31:0] csr_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [31:0]   mem [TABLE_DEPTH];
   logic [31:0]   rd_data_ff;

   logic [1:0]    func_ff, func_in;
   logic [31:0]   id_ff, id_in;
   logic [31:0]   master_ff, master_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          pend_ff, pend_in;
   logic [CW-1:0] pend_idx_ff, pend_idx_in;
   logic          hit_ff, hit_in;
   logic [CW-1:0] hit_slot_ff, hit_slot_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          match;
   logic          issue;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic [CW-1:0] slot_val;
   logic [CW-1:0] cnt_val;
   logic [1:0]    status_val;
   logic [CW+6:0] slot_ext;
   logic [CW+6:0] cnt_ext;

   assign match = pend_ff && (rd_data_ff == id_ff);

   always_comb begin
      func_in      = func_ff;
      id_in        = id_ff;
      master_in    = csr_valid ? csr_data : master_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      pend_idx_in  = idx_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      issue        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = pend_idx_ff[AW-1:0] - AW'(1);
      wr_data      = rd_data_ff;
      slot_val     = hit_slot_ff;
      cnt_val      = count_ff;
      status_val   = ST_DONE;

      if (cmd.load) begin
         func_in     = req_data.func;
         id_in       = req_data.card_id;
         idx_in      = '0;
         hit_in      = 1'b0;
         hit_slot_in = '0;
      end

      if (cmd.search) begin
         issue = (idx_ff < count_ff) && !hit_ff && !match;
         if (issue) idx_in = idx_ff + CW'(1);
         pend_in = issue;
         if (match) begin
            hit_in      = 1'b1;
            hit_slot_in = pend_idx_ff + CW'(1);
         end
      end

      if (cmd.shift_init) begin
         idx_in  = hit_slot_ff;
         pend_in = 1'b0;
      end

      if (cmd.shift) begin
         issue = (idx_ff < count_ff);
         if (issue) idx_in = idx_ff + CW'(1);
         pend_in = issue;
         wr_en   = pend_ff;
      end

      if (cmd.finish) begin
         case (func_ff)
            OP_LOOKUP: status_val = ST_DONE;
            OP_ADD: begin
               if (hit_ff) begin
                  status_val = ST_DUPLICATE;
               end else if (count_ff >= CW'(TABLE_DEPTH)) begin
                  status_val = ST_FULL;
                  slot_val   = '0;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[AW-1:0];
                  wr_data  = id_ff;
                  cnt_val  = count_ff + CW'(1);
                  slot_val = cnt_val;
               end
            end
            OP_DELETE: begin
               if (!hit_ff) status_val = ST_ABSENT;
               else cnt_val = count_ff - CW'(1);
            end
            OP_CLEAR: cnt_val = '0;
            default:  status_val = ST_DONE;
         endcase
         count_in     = cnt_val;
         rsp_valid_in = 1'b1;
      end

      slot_ext = {7'd0, slot_val};
      cnt_ext  = {7'd0, cnt_val};
      if (cmd.finish) begin
         rsp_in.found       = hit_ff;
         rsp_in.slot        = slot_ext[6:0];
         rsp_in.entry_count = cnt_ext[6:0];
         rsp_in.is_master   = (id_ff == master_ff);
         rsp_in.status      = status_val;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      id_ff       <= id_in;
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      hit_ff      <= hit_in;
      hit_slot_ff <= hit_slot_in;
      rsp_ff      <= rsp_in;
      if (reset) begin
         master_ff    <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         master_ff    <= master_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.search_done = hit_ff || (!pend_ff && (idx_ff >= count_ff));
   assign sts.hit         = hit_ff;
   assign sts.is_delete   = (func_ff == OP_DELETE);
   assign sts.shift_done  = !pend_ff && (idx_ff >= count_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[sv/card_id_whitelist_table_unit.sv]
// Top level of the card ID whitelist table: controller plus datapath.
// Depends on cidwl_pkg, cidwl_ctrl and cidwl_dp.
//
// Usage:
//   Request: drive req_data (func, card_id) and raise start; the word is
//   taken at a clock edge where start is high and busy is low.
//   Response: one word per request, on rsp_data for a single cycle with
//   rsp_valid high. The receiver cannot stall; it must take it then.
//   Master ID: written through csr_valid/csr_data; csr_ready is always high.
//   Write it only while busy is low.
// Timing:
//   The search reads one stored ID per cycle through the single memory read
//   port. A delete that hits then compacts the table at one entry per
//   cycle. A finish step follows; the response appears in the cycle after
//   it. busy drops as the response is shown, so a new request may start in
//   that cycle.
// Reset:
//   Synchronous reset empties the table and clears the master ID to zero.
module card_id_whitelist_table_unit import cidwl_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   cidwl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   cidwl_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held beyond one cycle");

   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd.finish))
      else $error("response without a finish step");

   a_full_no_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == ST_FULL)) |->
         (!rsp_data.found && (rsp_data.slot == 7'd0)))
      else $error("refused add reports a slot");

endmodule

[tb/sv/card_id_whitelist_table_unit_test.sv]
// Self-checking bench for card_id_whitelist_table_unit: a directed table, then
// phased random traffic, checked by typed rows or an in-bench table predictor.
// Depends on cidwl_pkg and card_id_whitelist_table_unit.
module card_id_whitelist_table_unit_test;
   import cidwl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH    = 64;
   localparam int POOL_SIZE      = 70;
   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_PRINTS     = 40;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_kind_type;

   typedef struct packed {
      req_type    word;
      logic       typed;
      rsp_type    want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;

   card_id_whitelist_table_unit #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [31:0] id_table [TABLE_DEPTH];
   int          id_count = 0;
   logic [31:0] master_card = '0;
   rsp_type     expected_rsp [$];
   dir_row_type dir_rows [$];
   logic [31:0] id_pool [POOL_SIZE];

   int errors = 0;
   int words_sent = 0;
   int words_seen = 0;
   int master_writes = 0;
   int hits_seen = 0;
   int dup_seen = 0;
   int absent_seen = 0;
   int full_seen = 0;
   int stall_cycles = 0;
   rsp_type want_rsp;

   function automatic rsp_type apply_card_op(req_type w);
      int      hit;
      rsp_type o;
      hit = 0;
      for (int i = 0; i < id_count && i < TABLE_DEPTH; i++)
         if (hit == 0 && id_table[i] == w.card_id) hit = i + 1;
      o.found  = (hit != 0);
      o.slot   = 7'(hit);
      o.status = ST_DONE;
      case (w.func)
         OP_LOOKUP: ;
         OP_ADD: begin
            if (hit != 0) begin
               o.status = ST_DUPLICATE;
            end else if (id_count >= TABLE_DEPTH) begin
               o.status = ST_FULL;
               o.slot   = '0;
            end else begin
               id_table[id_count] = w.card_id;
               id_count++;
               o.slot = 7'(id_count);
            end
         end
         OP_DELETE: begin
            if (hit == 0) begin
               o.status = ST_ABSENT;
            end else begin
               for (int i = hit; i < id_count && i < TABLE_DEPTH; i++)
                  id_table[i-1] = id_table[i];
               id_count--;
            end
         end
         default: id_count = 0;
      endcase
      o.entry_count = 7'(id_count);
      o.is_master   = (w.card_id == master_card);
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= MAX_PRINTS)
         $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
   endtask

   // Assumes the caller sits just after a rising edge.
   task automatic send_word(req_type w, logic typed, rsp_type typed_rsp);
      rsp_type pred;
      req_data <= w;
      start    <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      pred = apply_card_op(w);
      expected_rsp.push_back(typed ? typed_rsp : pred);
      words_sent++;
   endtask

   task automatic hold_off(int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic write_master(logic [31:0] v);
      start <= 1'b0;
      while (expected_rsp.size() != 0 || busy !== 1'b0) @(posedge clock);
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid   <= 1'b0;
      master_card  = v;
      master_writes++;
   endtask

   function automatic int pick_gap(logic quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(3, 1);
      return $urandom_range(200, 20);
   endfunction

   task automatic add_row(logic [1:0] func, logic [31:0] id, logic typed,
                          logic found, int slot, int cnt, logic is_master,
                          logic [1:0] status);
      dir_row_type row;
      row.word.func         = func;
      row.word.card_id      = id;
      row.typed             = typed;
      row.want.found        = found;
      row.want.slot         = 7'(slot);
      row.want.entry_count  = 7'(cnt);
      row.want.is_master    = is_master;
      row.want.status       = status;
      dir_rows.push_back(row);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         words_seen++;
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected response", 32'(rsp_data), '0);
         end else begin
            want_rsp = expected_rsp.pop_front();
            if (rsp_data.found !== want_rsp.found)
               report_mismatch("found", 32'(rsp_data.found), 32'(want_rsp.found));
            if (rsp_data.slot !== want_rsp.slot)
               report_mismatch("slot", 32'(rsp_data.slot), 32'(want_rsp.slot));
            if (rsp_data.entry_count !== want_rsp.entry_count)
               report_mismatch("entry_count", 32'(rsp_data.entry_count),
                               32'(want_rsp.entry_count));
            if (rsp_data.is_master !== want_rsp.is_master)
               report_mismatch("is_master", 32'(rsp_data.is_master),
                               32'(want_rsp.is_master));
            if (rsp_data.status !== want_rsp.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want_rsp.status));
            if (want_rsp.found) hits_seen++;
            if (want_rsp.status == ST_DUPLICATE) dup_seen++;
            if (want_rsp.status == ST_ABSENT) absent_seen++;
            if (want_rsp.status == ST_FULL) full_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("[card_id_whitelist_table_unit] ERROR");
         $finish;
      end
   end

   mix_kind_type kind;
   logic        quiet;
   logic [1:0]  func;
   logic [31:0] id;
   int          r;
   int          fill_ptr;

   initial begin
      fill_ptr = 0;
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = $urandom;

      add_row(OP_LOOKUP, 32'h0000_0000, 1'b1, 1'b0, 0, 0, 1'b1, ST_DONE);
      add_row(OP_DELETE, 32'hFFFF_FFFF, 1'b1, 1'b0, 0, 0, 1'b0, ST_ABSENT);
      add_row(OP_ADD,    32'hFFFF_FFFF, 1'b1, 1'b0, 1, 1, 1'b0, ST_DONE);
      add_row(OP_ADD,    32'hFFFF_FFFF, 1'b1, 1'b1, 1, 1, 1'b0, ST_DUPLICATE);
      add_row(OP_ADD,    32'h0000_0000, 1'b1, 1'b0, 2, 2, 1'b1, ST_DONE);
      add_row(OP_LOOKUP, 32'h0000_0000, 1'b1, 1'b1, 2, 2, 1'b1, ST_DONE);
      add_row(OP_ADD,    32'hA5A5_A5A5, 1'b0, 1'b0, 0, 0, 1'b0, ST_DONE);
      add_row(OP_ADD,    32'h5A5A_5A5A, 1'b0, 1'b0, 0, 0, 1'b0, ST_DONE);
      add_row(OP_ADD,    32'h8000_0001, 1'b0, 1'b0, 0, 0, 1'b0, ST_DONE);
      add_row(OP_DELETE, 32'h0000_0000, 1'b0, 1'b0, 0, 0, 1'b0, ST_DONE);
      add_row(OP_LOOKUP, 32'h5A5A_5A5A, 1'b0, 1'b0, 0, 0, 1'b0, ST_DONE);
      add_row(OP_DELETE, 32'h8000_0001, 1'b0, 1'b0, 0, 0, 1'b0, ST_DONE);
      add_row(OP_DELETE, 32'hFFFF_FFFF, 1'b0, 1'b0, 0, 0, 1'b0, ST_DONE);
      add_row(OP_LOOKUP, 32'h0000_0001, 1'b0, 1'b0, 0, 0, 1'b0, ST_DONE);
      add_row(OP_CLEAR,  32'hA5A5_A5A5, 1'b0, 1'b0, 0, 0, 1'b0, ST_DONE);
      add_row(OP_CLEAR,  32'h1234_5678, 1'b1, 1'b0, 0, 0, 1'b0, ST_DONE);
      add_row(OP_LOOKUP, 32'hA5A5_A5A5, 1'b1, 1'b0, 0, 0, 1'b0, ST_DONE);
      add_row(OP_ADD,    32'h0000_0001, 1'b0, 1'b0, 0, 0, 1'b0, ST_DONE);
      add_row(OP_DELETE, 32'h0000_0001, 1'b0, 1'b0, 0, 0, 1'b0, ST_DONE);
      add_row(OP_DELETE, 32'h0000_0001, 1'b1, 1'b0, 0, 0, 1'b0, ST_ABSENT);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[k]) begin
         send_word(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].want);
         hold_off(pick_gap(1'b0));
      end

      for (int p = 0; p < PHASES; p++) begin
         if (p == 0) begin
            kind = MIX_FILL;
            write_master(32'hFFFF_FFFF);
         end else if (p == 1) begin
            kind = MIX_DRAIN;
            write_master(32'h0000_0000);
         end else begin
            kind = (p == 2) ? MIX_FILL : mix_kind_type'($urandom_range(2));
            r = $urandom_range(3);
            if (r < 2)
               write_master(id_pool[$urandom_range(POOL_SIZE-1)]);
            else if (r == 2)
               write_master($urandom);
            else
               write_master($urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000);
         end
         quiet = ($urandom_range(3) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(99);
            case (kind)
               MIX_FILL:  func = r < 80 ? OP_ADD : r < 92 ? OP_LOOKUP : OP_DELETE;
               MIX_DRAIN: func = r < 60 ? OP_DELETE : r < 80 ? OP_LOOKUP :
                                 r < 96 ? OP_ADD : OP_CLEAR;
               default:   func = r < 35 ? OP_ADD : r < 65 ? OP_LOOKUP :
                                 r < 97 ? OP_DELETE : OP_CLEAR;
            endcase
            if ($urandom_range(9) == 0) begin
               id = $urandom;
            end else if (func == OP_ADD && kind == MIX_FILL) begin
               id       = id_pool[fill_ptr];
               fill_ptr = (fill_ptr + 1) % POOL_SIZE;
            end else begin
               id = id_pool[$urandom_range(POOL_SIZE-1)];
            end
            send_word('{func: func, card_id: id}, 1'b0, '0);
            hold_off(pick_gap(quiet));
         end
      end

      start <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (2 * TABLE_DEPTH + 10) @(posedge clock);

      $display("run covered %0d requests, %0d responses, %0d master ID writes",
               words_sent, words_seen, master_writes);
      $display("hits %0d, duplicate adds %0d, absent deletes %0d, adds to full table %0d",
               hits_seen, dup_seen, absent_seen, full_seen);
      if (errors == 0)
         $display("[card_id_whitelist_table_unit] OK");
      else
         $display("[card_id_whitelist_table_unit] ERROR");
      $finish;
   end

endmodule

[sim.f]
sv/cidwl_pkg.sv
sv/cidwl_ctrl.sv
sv/cidwl_dp.sv
sv/card_id_whitelist_table_unit.sv
tb/sv/card_id_whitelist_table_unit_test.sv
